// File: design/mbs_pkg.sv
// Shared types, codes and constants of the motor brake sequencer.
`timescale 1ns / 1ps
`default_nettype none
package mbs_pkg;

    localparam int CfgIdxWidth = 3;
    localparam int QueueDepth  = 4;
    localparam int QueuePtrW   = $clog2(QueueDepth);

    localparam logic [CfgIdxWidth-1:0] CFG_RELEASE_TICKS   = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_ENGAGE_TICKS    = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_SAFE_ZERO_TICKS = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_STILL_BAND      = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_CURRENT_MAX     = 3'd4;
    localparam logic [CfgIdxWidth-1:0] CFG_CURRENT_MIN     = 3'd5;
    localparam logic [CfgIdxWidth-1:0] CFG_APPROACH_RATIO  = 3'd6;

    localparam logic [1:0] DIR_POSITIVE = 2'd1;
    localparam logic [1:0] DIR_NEGATIVE = 2'd2;

    typedef enum logic [1:0] {
        MODE_STOP  = 2'd0,
        MODE_SPEED = 2'd1,
        MODE_POS   = 2'd2,
        MODE_FAULT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        BRK_LOCKED    = 2'd0,
        BRK_RELEASING = 2'd1,
        BRK_FREE      = 2'd2,
        BRK_ENGAGING  = 2'd3
    } t_brake;

    typedef struct packed {
        logic [15:0]        release_ticks;
        logic [15:0]        engage_ticks;
        logic [15:0]        safe_zero_ticks;
        logic [15:0]        still_band;
        logic [13:0]        current_max_ma;
        logic signed [14:0] current_min_ma;
        logic [8:0]         approach_ratio_q8;
    } t_cfg;

    // Classified tick as it waits in the queue.
    typedef struct packed {
        logic               mode_write;
        logic [1:0]         mode_value;
        logic               fault;
        logic               still_incl;
        logic               still_excl;
        logic signed [14:0] limit_high;
        logic signed [14:0] limit_low;
    } t_cls;

    typedef struct packed {
        logic               brake_released;
        logic               loop_active;
        logic               hold_targets;
        logic               clear_integrators;
        logic signed [14:0] current_limit_high;
        logic signed [14:0] current_limit_low;
        logic               safe_to_zero;
        logic [1:0]         brake_phase;
        logic [1:0]         mode_now;
    } t_res;

endpackage
`default_nettype wire

// File: design/mbs_front.sv
// Front end: decodes an input item, checks the standstill band and works out current limits.
`timescale 1ns / 1ps
`default_nettype none
module mbs_front (
    input  wire mbs_pkg::t_cfg i_cfg,
    input  wire logic          i_mode_write,
    input  wire logic [1:0]    i_mode_value,
    input  wire logic          i_limit_fault,
    input  wire logic          i_bit_fault,
    input  wire logic          i_limit_reached,
    input  wire logic [1:0]    i_limit_direction,
    input  wire logic [16:0]   i_speed_now,
    output mbs_pkg::t_cls      o_cls
);
    import mbs_pkg::*;

    logic signed [17:0] speed_ext;
    logic signed [17:0] band_pos;
    logic signed [17:0] band_neg;
    logic [22:0]        prod_hi;
    logic [14:0]        mag_lo;
    logic [23:0]        prod_lo;
    logic [14:0]        q_hi;
    logic [15:0]        q_lo;
    logic               min_positive;
    logic signed [14:0] scaled_hi;
    logic signed [14:0] scaled_lo;

    assign speed_ext = {i_speed_now[16], i_speed_now};
    assign band_pos  = {2'b00, i_cfg.still_band};
    assign band_neg  = -band_pos;

    // Magnitude of the lower limit; the most negative value maps to 16384.
    assign min_positive = !i_cfg.current_min_ma[14] && (i_cfg.current_min_ma != 15'sd0);
    assign mag_lo = i_cfg.current_min_ma[14] ? 15'(-i_cfg.current_min_ma)
                                             : 15'(i_cfg.current_min_ma);

    assign prod_hi = 23'(i_cfg.current_max_ma) * 23'(i_cfg.approach_ratio_q8);
    assign prod_lo = 24'(mag_lo) * 24'(i_cfg.approach_ratio_q8);
    assign q_hi    = prod_hi[22:8];
    assign q_lo    = prod_lo[23:8];

    always_comb begin
        scaled_hi = q_hi[14] ? 15'sd16383 : $signed(q_hi);
        if (min_positive) begin
            scaled_lo = (q_lo > 16'd16383) ? 15'sd16383 : $signed(q_lo[14:0]);
        end else begin
            scaled_lo = (q_lo > 16'd16384) ? $signed(15'h4000) : $signed(15'(-q_lo[14:0]));
        end
    end

    always_comb begin
        o_cls.mode_write = i_mode_write;
        o_cls.mode_value = i_mode_value;
        o_cls.fault      = i_limit_fault | i_bit_fault;
        o_cls.still_incl = (speed_ext >= band_neg) && (speed_ext <= band_pos);
        o_cls.still_excl = (speed_ext > band_neg) && (speed_ext < band_pos);
        o_cls.limit_high = $signed({1'b0, i_cfg.current_max_ma});
        o_cls.limit_low  = i_cfg.current_min_ma;
        if (i_limit_reached) begin
            if (i_limit_direction == DIR_POSITIVE) begin
                o_cls.limit_high = 15'sd0;
            end else if (i_limit_direction == DIR_NEGATIVE) begin
                o_cls.limit_low = 15'sd0;
            end
        end else if (i_limit_direction == DIR_POSITIVE) begin
            o_cls.limit_high = scaled_hi;
        end else if (i_limit_direction == DIR_NEGATIVE) begin
            o_cls.limit_low = scaled_lo;
        end
    end

endmodule
`default_nettype wire

// File: design/mbs_queue.sv
// Short FIFO of classified items between the front and the back end.
`timescale 1ns / 1ps
`default_nettype none
module mbs_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mbs_pkg::t_cls i_item,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output mbs_pkg::t_cls      o_item
);
    import mbs_pkg::*;

    t_cls               r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr_ptr;
    logic [QueuePtrW-1:0] r_rd_ptr;
    logic [QueuePtrW:0]   r_count;
    logic [QueuePtrW:0]   n_count;

    assign o_full  = (r_count == (QueuePtrW+1)'(QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// File: design/mbs_back.sv
// Back end: mode latch, brake sequence, timers and the registered result.
`timescale 1ns / 1ps
`default_nettype none
module mbs_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mbs_pkg::t_cfg i_cfg,
    input  wire logic          i_q_valid,
    input  wire mbs_pkg::t_cls i_q_item,
    output logic               o_q_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output mbs_pkg::t_res      o_res
);
    import mbs_pkg::*;

    t_mode       r_mode;
    t_mode       n_mode;
    t_brake      r_brake;
    t_brake      n_brake;
    t_brake      brake_mid;
    logic [15:0] r_brake_timer;
    logic [15:0] n_brake_timer;
    logic [15:0] timer_mid;
    logic [15:0] timer_inc;
    logic [15:0] r_still_timer;
    logic [15:0] n_still_timer;
    logic        hold_entry;
    logic        release_done;
    logic        engage_done;
    logic        r_out_valid;
    t_res        r_out;
    t_res        n_out;

    assign o_q_pop = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // Next state: still timer, mode latch, mode-driven brake transition, then phase timing.
    always_comb begin
        if (i_q_item.still_incl && (r_brake == BRK_LOCKED)) begin
            n_still_timer = (r_still_timer < i_cfg.safe_zero_ticks) ? r_still_timer + 1'b1
                                                                     : r_still_timer;
        end else begin
            n_still_timer = '0;
        end

        n_mode = r_mode;
        if (i_q_item.mode_write) begin
            n_mode = t_mode'(i_q_item.mode_value);
        end
        if (i_q_item.fault) begin
            n_mode = MODE_FAULT;
        end

        brake_mid  = r_brake;
        timer_mid  = r_brake_timer;
        hold_entry = 1'b0;
        if (n_mode == MODE_FAULT) begin
            brake_mid = BRK_LOCKED;
        end else if (n_mode == MODE_STOP) begin
            if (r_brake == BRK_FREE) begin
                if (i_q_item.still_excl) begin
                    brake_mid = BRK_ENGAGING;
                    timer_mid = '0;
                end else begin
                    hold_entry = 1'b1;
                end
            end
        end else if (r_brake == BRK_LOCKED) begin
            brake_mid  = BRK_RELEASING;
            timer_mid  = '0;
            hold_entry = 1'b1;
        end

        timer_inc    = (timer_mid == 16'hFFFF) ? timer_mid : timer_mid + 1'b1;
        release_done = (timer_inc >= i_cfg.release_ticks);
        engage_done  = (timer_inc >= i_cfg.engage_ticks);

        n_brake       = brake_mid;
        n_brake_timer = timer_mid;
        case (brake_mid)
            BRK_RELEASING: begin
                n_brake_timer = timer_inc;
                if (release_done) begin
                    n_brake = BRK_FREE;
                end
            end
            BRK_ENGAGING: begin
                n_brake_timer = timer_inc;
                if (engage_done) begin
                    n_brake = BRK_LOCKED;
                end
            end
            default: begin
            end
        endcase
    end

    // Outputs of the tick, decided by the phase after the mode-driven transition.
    always_comb begin
        n_out                    = '0;
        n_out.hold_targets       = hold_entry;
        n_out.current_limit_high = i_q_item.limit_high;
        n_out.current_limit_low  = i_q_item.limit_low;
        n_out.safe_to_zero       = (n_still_timer >= i_cfg.safe_zero_ticks);
        n_out.brake_phase        = n_brake;
        n_out.mode_now           = n_mode;
        case (brake_mid)
            BRK_LOCKED: begin
                n_out.clear_integrators = 1'b1;
            end
            BRK_RELEASING: begin
                n_out.brake_released = 1'b1;
                n_out.loop_active    = 1'b1;
                if (!release_done) begin
                    n_out.hold_targets = 1'b1;
                end
            end
            BRK_ENGAGING: begin
                n_out.hold_targets = 1'b1;
                n_out.loop_active  = !engage_done;
            end
            default: begin
                n_out.brake_released = 1'b1;
                n_out.loop_active    = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_STOP;
            r_brake       <= BRK_LOCKED;
            r_brake_timer <= '0;
            r_still_timer <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_mode        <= n_mode;
                r_brake       <= n_brake;
                r_brake_timer <= n_brake_timer;
                r_still_timer <= n_still_timer;
                r_out_valid   <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// File: design/motor_brake_sequencer_unit.sv
// Top level of the motor brake sequencer: configuration registers, front end, queue, back end.
// Each accepted item is registered in the queue, then in the back end's output register.
// Throughput: one item per cycle unless the output stalls; each pop updates the back end state.
// The four-entry queue lets the input keep accepting items while the output side is stalled.
// Reset is synchronous and active low: mode stop, brake locked, timers zero, queue empty,
// and every configuration register back to its default value.
`timescale 1ns / 1ps
`default_nettype none
module motor_brake_sequencer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input items: [0] mode_write, [2:1] mode_value, [3] limit_fault, [4] bit_fault,
    // [5] limit_reached, [7:6] limit_direction, [24:8] speed_now, [31:25] zero.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,
    // Result items: [0] brake_released, [1] loop_active, [2] hold_targets,
    // [3] clear_integrators, [18:4] current_limit_high, [33:19] current_limit_low,
    // [34] safe_to_zero, [36:35] brake_phase, [38:37] mode_now, [39] zero.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_wdata
);
    import mbs_pkg::*;

    t_cfg r_cfg;
    t_cls front_cls;
    t_cls queue_item;
    t_res back_res;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;
    logic in_push;

    // Configuration registers. Writes must come only while the block is idle, so that no
    // item ever sees a half-updated set; the block itself does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.release_ticks     <= 16'd1500;
            r_cfg.engage_ticks      <= 16'd1000;
            r_cfg.safe_zero_ticks   <= 16'd5000;
            r_cfg.still_band        <= 16'd16;
            r_cfg.current_max_ma    <= 14'd9340;
            r_cfg.current_min_ma    <= -15'sd9340;
            r_cfg.approach_ratio_q8 <= 9'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RELEASE_TICKS:   r_cfg.release_ticks     <= i_cfg_wdata;
                CFG_ENGAGE_TICKS:    r_cfg.engage_ticks      <= i_cfg_wdata;
                CFG_SAFE_ZERO_TICKS: r_cfg.safe_zero_ticks   <= i_cfg_wdata;
                CFG_STILL_BAND:      r_cfg.still_band        <= i_cfg_wdata;
                CFG_CURRENT_MAX:     r_cfg.current_max_ma    <= i_cfg_wdata[13:0];
                CFG_CURRENT_MIN:     r_cfg.current_min_ma    <= $signed(i_cfg_wdata[14:0]);
                CFG_APPROACH_RATIO:  r_cfg.approach_ratio_q8 <= i_cfg_wdata[8:0];
                default: begin
                end
            endcase
        end
    end

    // The front end is stateless: an accepted item is classified and written
    // straight into the queue, which is the register after the limit multipliers.
    assign o_s_axis_tready = !queue_full;
    assign in_push         = i_s_axis_tvalid && !queue_full;

    mbs_front u_front (
        .i_cfg             (r_cfg),
        .i_mode_write      (i_s_axis_tdata[0]),
        .i_mode_value      (i_s_axis_tdata[2:1]),
        .i_limit_fault     (i_s_axis_tdata[3]),
        .i_bit_fault       (i_s_axis_tdata[4]),
        .i_limit_reached   (i_s_axis_tdata[5]),
        .i_limit_direction (i_s_axis_tdata[7:6]),
        .i_speed_now       (i_s_axis_tdata[24:8]),
        .o_cls             (front_cls)
    );

    mbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_push),
        .i_item  (front_cls),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_item  (queue_item)
    );

    // The back end pops one waiting item per cycle whenever its output register is
    // empty or being taken, and updates the brake state on each pop.
    mbs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (queue_valid),
        .i_q_item  (queue_item),
        .o_q_pop   (queue_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_res     (back_res)
    );

    assign o_m_axis_tdata = {1'b0,
                             back_res.mode_now,
                             back_res.brake_phase,
                             back_res.safe_to_zero,
                             back_res.current_limit_low,
                             back_res.current_limit_high,
                             back_res.clear_integrators,
                             back_res.hold_targets,
                             back_res.loop_active,
                             back_res.brake_released};

endmodule
`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the motor brake sequencer: stream driver, monitor and predictor.
`timescale 1ns / 1ps
module tb;
    import mbs_pkg::*;

    // The package names only the two real limit directions; the other two codes count as no limit.
    localparam logic [1:0] DIR_NONE   = 2'd0;
    localparam logic [1:0] DIR_SPARE  = 2'd3;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 135;
    localparam int SETTLE_TICKS = 10;    // results pass a queue and an output register; this leaves margin
    localparam int QUIET_LIMIT  = 1000;  // far above the longest gap, stall and register write

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [15:0] cfg_wdata = '0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [39:0] o_m_axis_tdata;

    // Items waiting to be sent and the results they are predicted to produce, oldest first.
    logic [31:0] tick_words_q[$];
    t_res        tick_results_q[$];

    // Predictor state and its copy of the register file.
    t_mode       mode_q = MODE_STOP;
    t_brake      brake_q = BRK_LOCKED;
    logic [15:0] brake_cnt = '0;
    logic [15:0] still_cnt = '0;
    t_cfg        cfg_model = '{release_ticks: 16'd1500, engage_ticks: 16'd1000,
                               safe_zero_ticks: 16'd5000, still_band: 16'd16,
                               current_max_ma: 14'd9340, current_min_ma: -15'sd9340,
                               approach_ratio_q8: 9'd64};

    int send_gap_max = 0;
    int recv_stall_max = 0;
    int send_wait = 0;
    int recv_wait = 0;
    int recv_draw;
    int quiet_cycles = 0;
    int items_sent = 0;
    int results_seen = 0;
    int settings_used = 1;
    int n_fail = 0;

    motor_brake_sequencer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        // [0] mode_write, [2:1] mode_value, [3] limit_fault, [4] bit_fault,
        // [5] limit_reached, [7:6] limit_direction, [24:8] speed_now.
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        // [0] brake_released, [1] loop_active, [2] hold_targets, [3] clear_integrators,
        // [18:4] current_limit_high, [33:19] current_limit_low, [34] safe_to_zero,
        // [36:35] brake_phase, [38:37] mode_now.
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Half of the items go out back to back; the rest wait a random number of cycles.
    function automatic int idle_draw(input int top);
        return ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, top));
    endfunction

    function automatic logic [31:0] pack_tick(input logic mw, input logic [1:0] mv,
                                              input logic lf, input logic bf, input logic lr,
                                              input logic [1:0] ld, input int spd);
        return {7'd0, 17'(spd), ld, lr, bf, lf, mv, mw};
    endfunction

    // Advances the predicted sequencer by one control tick and returns the expected result.
    // The still timer looks at the brake state from before the tick; the mode write comes
    // ahead of the fault override, and the transitions come ahead of the phase actions.
    function automatic t_res brake_tick(input logic [31:0] word);
        int   spd, band, hi, lo, ratio, mn;
        t_res r;
        spd   = int'($signed(word[24:8]));
        band  = int'(cfg_model.still_band);
        ratio = int'(cfg_model.approach_ratio_q8);
        mn    = int'($signed(cfg_model.current_min_ma));
        hi    = int'(cfg_model.current_max_ma);
        lo    = mn;
        r     = '0;

        if (spd >= -band && spd <= band && brake_q == BRK_LOCKED) begin
            if (still_cnt < cfg_model.safe_zero_ticks) still_cnt++;
        end else begin
            still_cnt = '0;
        end

        if (word[0]) mode_q = t_mode'(word[2:1]);
        if (word[3] || word[4]) mode_q = MODE_FAULT;

        if (mode_q == MODE_FAULT) begin
            brake_q = BRK_LOCKED;
        end else if (mode_q == MODE_STOP) begin
            // Engaging starts only strictly inside the band; on the edge the targets hold.
            if (brake_q == BRK_FREE) begin
                if (spd > -band && spd < band) begin
                    brake_q   = BRK_ENGAGING;
                    brake_cnt = '0;
                end else begin
                    r.hold_targets = 1'b1;
                end
            end
        end else if (brake_q == BRK_LOCKED) begin
            brake_q        = BRK_RELEASING;
            brake_cnt      = '0;
            r.hold_targets = 1'b1;
        end

        case (brake_q)
            BRK_LOCKED: begin
                r.clear_integrators = 1'b1;
            end
            BRK_RELEASING: begin
                r.brake_released = 1'b1;
                r.loop_active    = 1'b1;
                if (brake_cnt != 16'hFFFF) brake_cnt++;
                if (brake_cnt >= cfg_model.release_ticks) brake_q = BRK_FREE;
                else r.hold_targets = 1'b1;
            end
            BRK_ENGAGING: begin
                // The tick that locks the brake runs no loop but clears nothing either.
                r.hold_targets = 1'b1;
                if (brake_cnt != 16'hFFFF) brake_cnt++;
                if (brake_cnt >= cfg_model.engage_ticks) brake_q = BRK_LOCKED;
                else r.loop_active = 1'b1;
            end
            default: begin
                r.brake_released = 1'b1;
                r.loop_active    = 1'b1;
            end
        endcase

        // Current limits: cut at the cut-off distance, scaled while approaching, saturated
        // to the 15-bit field when the ratio goes above one.
        if (word[5]) begin
            if (word[7:6] == DIR_POSITIVE) hi = 0;
            else if (word[7:6] == DIR_NEGATIVE) lo = 0;
        end else if (word[7:6] == DIR_POSITIVE) begin
            hi = (hi * ratio) >> 8;
        end else if (word[7:6] == DIR_NEGATIVE) begin
            lo = (mn > 0) ? ((mn * ratio) >> 8) : -(((-mn) * ratio) >> 8);
        end
        hi = (hi > 16383) ? 16383 : hi;
        lo = (lo > 16383) ? 16383 : (lo < -16384) ? -16384 : lo;

        r.current_limit_high = 15'(hi);
        r.current_limit_low  = 15'(lo);
        r.safe_to_zero       = (still_cnt >= cfg_model.safe_zero_ticks);
        r.brake_phase        = brake_q;
        r.mode_now           = mode_q;
        return r;
    endfunction

    // Mostly ordinary ticks with a mode write now and then, speeds around the standstill band
    // so that both brake sequences run to their ends, and rare faults.
    function automatic logic [31:0] random_tick();
        int         b, spd, pick;
        logic [1:0] mv;
        b    = (cfg_model.still_band > 16'd65534) ? 65534 : int'(cfg_model.still_band);
        pick = $urandom_range(0, 15);
        mv   = (pick < 6) ? MODE_STOP : (pick < 11) ? MODE_SPEED :
               (pick < 15) ? MODE_POS : MODE_FAULT;
        case ($urandom_range(0, 3))
            0: spd = int'($urandom_range(0, 131071)) - 65536;
            1, 2: spd = int'($urandom_range(0, 2 * b + 2)) - (b + 1);
            default: spd = int'($urandom_range(0, 128)) - 64;
        endcase
        return pack_tick($urandom_range(0, 7) == 0, mv, $urandom_range(0, 39) == 0,
                         $urandom_range(0, 39) == 0, $urandom_range(0, 1) == 1,
                         2'($urandom_range(0, 3)), spd);
    endfunction

    task automatic cmp_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    task automatic check_result(input logic [39:0] word);
        t_res want;
        if (tick_results_q.size() == 0) begin
            $error("result item with no expected result waiting: %h", word);
            n_fail++;
        end else begin
            want = tick_results_q.pop_front();
            results_seen++;
            cmp_field("brake_released", want.brake_released, word[0]);
            cmp_field("loop_active", want.loop_active, word[1]);
            cmp_field("hold_targets", want.hold_targets, word[2]);
            cmp_field("clear_integrators", want.clear_integrators, word[3]);
            cmp_field("current_limit_high", $signed(want.current_limit_high),
                      $signed(word[18:4]));
            cmp_field("current_limit_low", $signed(want.current_limit_low),
                      $signed(word[33:19]));
            cmp_field("safe_to_zero", want.safe_to_zero, word[34]);
            cmp_field("brake_phase", want.brake_phase, word[36:35]);
            cmp_field("mode_now", want.mode_now, word[38:37]);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
    endtask

    // Writes all seven registers back to back; the block is idle whenever this runs.
    task automatic apply_config(input t_cfg c);
        write_reg(CFG_RELEASE_TICKS, c.release_ticks);
        write_reg(CFG_ENGAGE_TICKS, c.engage_ticks);
        write_reg(CFG_SAFE_ZERO_TICKS, c.safe_zero_ticks);
        write_reg(CFG_STILL_BAND, c.still_band);
        write_reg(CFG_CURRENT_MAX, {2'b00, c.current_max_ma});
        write_reg(CFG_CURRENT_MIN, {c.current_min_ma[14], c.current_min_ma});
        write_reg(CFG_APPROACH_RATIO, {7'd0, c.approach_ratio_q8});
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cfg_model = c;
        settings_used++;
        @(negedge i_clk);
    endtask

    // Holds the sender back until every item is out and every predicted result has come.
    task automatic wait_quiet();
        while (tick_words_q.size() != 0 || s_tvalid || tick_results_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    // Driver: predicts the accepted item at the edge where it goes in, then either idles for
    // the drawn gap or puts up the next pending item. tvalid gets one assignment per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid  <= 1'b0;
            send_wait <= 0;
        end else if (!s_tvalid || o_s_axis_tready) begin
            if (s_tvalid) begin
                tick_results_q.push_back(brake_tick(s_tdata));
                items_sent++;
            end
            if (send_wait != 0) begin
                send_wait <= send_wait - 1;
                s_tvalid  <= 1'b0;
            end else if (tick_words_q.size() != 0) begin
                s_tdata   <= tick_words_q.pop_front();
                s_tvalid  <= 1'b1;
                send_wait <= idle_draw(send_gap_max);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result, then drops tready for a drawn number of cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
        end else if (o_m_axis_tvalid && m_tready) begin
            check_result(o_m_axis_tdata);
            recv_draw = idle_draw(recv_stall_max);
            recv_wait <= recv_draw;
            m_tready  <= (recv_draw == 0);
        end else if (recv_wait != 0) begin
            recv_wait <= recv_wait - 1;
            m_tready  <= (recv_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: a run of cycles with no item moving on either side means the block hung.
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_cfg c;
        int   p, k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: both real limit directions with and without the cut-off, the speed
        // extremes, a written mode value of three, and both faults breaking a release.
        send_gap_max   = 18;
        recv_stall_max = 18;
        tick_words_q.push_back(pack_tick(0, MODE_STOP, 0, 0, 0, DIR_NONE, 0));
        tick_words_q.push_back(pack_tick(0, MODE_STOP, 0, 0, 0, DIR_POSITIVE, 3));
        tick_words_q.push_back(pack_tick(0, MODE_STOP, 0, 0, 0, DIR_NEGATIVE, -5));
        tick_words_q.push_back(pack_tick(0, MODE_STOP, 0, 0, 1, DIR_POSITIVE, 16));
        tick_words_q.push_back(pack_tick(0, MODE_STOP, 0, 0, 1, DIR_NEGATIVE, -16));
        tick_words_q.push_back(pack_tick(0, MODE_POS, 0, 0, 1, DIR_SPARE, 65535));
        tick_words_q.push_back(pack_tick(0, MODE_STOP, 0, 0, 0, DIR_NONE, -65536));
        tick_words_q.push_back(pack_tick(1, MODE_FAULT, 0, 0, 0, DIR_NONE, 0));
        tick_words_q.push_back(pack_tick(1, MODE_SPEED, 0, 0, 0, DIR_NONE, 0));
        tick_words_q.push_back(pack_tick(0, MODE_STOP, 1, 0, 0, DIR_NONE, 200));
        tick_words_q.push_back(pack_tick(1, MODE_POS, 0, 0, 0, DIR_NEGATIVE, 0));
        tick_words_q.push_back(pack_tick(0, MODE_STOP, 0, 1, 0, DIR_NONE, 0));
        tick_words_q.push_back(pack_tick(1, MODE_STOP, 0, 0, 0, DIR_NONE, 0));
        wait_quiet();

        // Short timers and a ratio above one: standstill up to the zeroing point with speed on
        // the band edges, a full release, saturated limits, a stop on the band edge that only
        // holds the targets, then an engage that locks the brake.
        c = '{release_ticks: 16'd2, engage_ticks: 16'd2, safe_zero_ticks: 16'd3,
              still_band: 16'd16, current_max_ma: 14'd16383, current_min_ma: -15'sd16384,
              approach_ratio_q8: 9'd511};
        apply_config(c);
        tick_words_q.push_back(pack_tick(0, MODE_STOP, 0, 0, 0, DIR_NONE, 16));
        tick_words_q.push_back(pack_tick(0, MODE_STOP, 0, 0, 0, DIR_NONE, -16));
        tick_words_q.push_back(pack_tick(0, MODE_STOP, 0, 0, 0, DIR_NONE, 0));
        tick_words_q.push_back(pack_tick(0, MODE_STOP, 0, 0, 0, DIR_NONE, 17));
        tick_words_q.push_back(pack_tick(1, MODE_SPEED, 0, 0, 0, DIR_NONE, 0));
        tick_words_q.push_back(pack_tick(0, MODE_STOP, 0, 0, 0, DIR_NONE, 0));
        tick_words_q.push_back(pack_tick(0, MODE_STOP, 0, 0, 0, DIR_POSITIVE, 300));
        tick_words_q.push_back(pack_tick(0, MODE_STOP, 0, 0, 0, DIR_NEGATIVE, -300));
        tick_words_q.push_back(pack_tick(1, MODE_STOP, 0, 0, 0, DIR_NONE, 16));
        tick_words_q.push_back(pack_tick(0, MODE_STOP, 0, 0, 0, DIR_NONE, -15));
        tick_words_q.push_back(pack_tick(0, MODE_STOP, 0, 0, 0, DIR_NONE, 0));
        tick_words_q.push_back(pack_tick(0, MODE_STOP, 0, 0, 0, DIR_NONE, 0));
        wait_quiet();

        // Random phases. The first three use extreme settings: everything zero, everything at
        // its top with a positive lower limit, and unit timers with the full current range.
        for (p = 0; p < N_PHASES; p++) begin
            case (p)
                0: c = '0;
                1: c = '{release_ticks: 16'hFFFF, engage_ticks: 16'hFFFF,
                         safe_zero_ticks: 16'hFFFF, still_band: 16'hFFFF,
                         current_max_ma: 14'd16383, current_min_ma: 15'sd16383,
                         approach_ratio_q8: 9'd511};
                2: c = '{release_ticks: 16'd1, engage_ticks: 16'd1, safe_zero_ticks: 16'd1,
                         still_band: 16'd1, current_max_ma: 14'd16383,
                         current_min_ma: -15'sd16384, approach_ratio_q8: 9'd256};
                default: begin
                    c.release_ticks     = 16'($urandom_range(0, 12));
                    c.engage_ticks      = 16'($urandom_range(0, 12));
                    c.safe_zero_ticks   = 16'($urandom_range(0, 20));
                    c.still_band        = 16'($urandom_range(0, 300));
                    c.current_max_ma    = 14'($urandom);
                    c.current_min_ma    = ($urandom_range(0, 4) == 0) ?
                                          15'($urandom_range(0, 16383)) :
                                          15'(-int'($urandom_range(0, 16384)));
                    c.approach_ratio_q8 = 9'($urandom);
                end
            endcase
            apply_config(c);
            // Rotate the idling so that some phases run with no gaps on one side or the other.
            send_gap_max   = (p % 3 == 1) ? 0 : 18;
            recv_stall_max = (p % 3 == 2) ? 0 : 18;
            for (k = 0; k < PHASE_ITEMS; k++) tick_words_q.push_back(random_tick());
            wait_quiet();
        end

        $display("Ran %0d items and checked %0d results under %0d register settings.",
                 items_sent, results_seen, settings_used);
        $display("Covered brake release and engage, fault stops, standstill zeroing and "
                 , "current limit scaling, with random idling on both sides.");
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
